// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Constants and helper functions shared by the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned Rounds = 80;
  localparam int unsigned RoundW = 7;

  localparam logic [WordW-1:0] Iv0 = 32'h67452301;
  localparam logic [WordW-1:0] Iv1 = 32'hefcdab89;
  localparam logic [WordW-1:0] Iv2 = 32'h98badcfe;
  localparam logic [WordW-1:0] Iv3 = 32'h10325476;
  localparam logic [WordW-1:0] Iv4 = 32'hc3d2e1f0;

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PadByte = 8'h80;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic step;
  } sha1_round_ctl_t;

  // Round function value for a given round number.
  function automatic logic [WordW-1:0] sha1_f(input logic [RoundW-1:0] t,
                                              input logic [WordW-1:0] b,
                                              input logic [WordW-1:0] c,
                                              input logic [WordW-1:0] d);
    logic [WordW-1:0] r;
    if (t < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      r = b ^ c ^ d;
    end else if (t < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  // Round constant for a given round number.
  function automatic logic [WordW-1:0] sha1_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] r;
    if (t < 7'd20) begin
      r = K0;
    end else if (t < 7'd40) begin
      r = K1;
    end else if (t < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha1_rounds.sv =====
// ----------------------------------------------------------------------------
// sha1_rounds
// Working variables a..e and one SHA-1 round per step, fed one schedule word
// per step by the caller.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_rounds
  import sha1_pkg::*;
(
  input  wire logic                   clk,
  input  wire sha1_round_ctl_t        ctl,
  input  wire logic [RoundW-1:0]      round,
  input  wire logic [WordW-1:0]       w_word,
  input  wire logic [5*WordW-1:0]     chain_in,
  output logic      [5*WordW-1:0]     work_out
);

  logic [WordW-1:0] a, b, c, d, e;
  logic [WordW-1:0] t_sum;

  // The new a value of this round.
  always_comb begin
    t_sum = {a[26:0], a[31:27]} + sha1_f(round, b, c, d) + e + w_word + sha1_k(round);
  end

  // Load from the chain at the start of a block, then step.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain_in[5*WordW-1:4*WordW];
      b <= chain_in[4*WordW-1:3*WordW];
      c <= chain_in[3*WordW-1:2*WordW];
      d <= chain_in[2*WordW-1:WordW];
      e <= chain_in[WordW-1:0];
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t_sum;
    end
  end

  assign work_out = {a, b, c, d, e};

endmodule

`default_nettype wire

// ===== sv/sha1_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 over a stream of big-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Message words are written into a 16-entry block memory, taken while
// in_stall is low. The sixteenth word of a block starts the 80 round
// compression, which runs at one round per cycle. The message schedule is
// kept in place in the same memory (read, expand, write back). A full block
// therefore stalls input for one read setup, 80 rounds and one fold. The end
// word inserts the padding and length one word per cycle,
// may compress twice, then presents the five digest words H0..H4 on the
// output, the last flagged by digest_last. New input is taken once the
// fifth is delivered.
`default_nettype none

module sha1_stream_hasher_core
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WordW-1:0]  msg_word,
  input  wire logic [2:0]        valid_bytes,
  input  wire logic              msg_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WordW-1:0]  digest_word,
  output logic                   digest_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN_HI, S_LEN_LO, S_READ, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t state;
  logic [SlotW-1:0]  slot;
  logic [63:0]       bit_length;
  logic [WordW-1:0]  chain [5];
  logic [RoundW-1:0] round;
  logic              finishing;
  logic [2:0]        out_idx;
  logic              pend_pad;
  logic              done_msg;

  // Block memory and its registered read ports.
  logic [WordW-1:0]  mem [BlockWords];
  logic              mem_we;
  logic [SlotW-1:0]  mem_wa;
  logic [WordW-1:0]  mem_wd;
  logic [SlotW-1:0]  ra0, ra1, ra2, ra3;
  logic [WordW-1:0]  rd0, rd1, rd2, rd3;

  sha1_round_ctl_t   rctl;
  logic [WordW-1:0]  w_cur;
  logic [WordW-1:0]  w_x;
  logic [5*WordW-1:0] work;

  logic              acc;
  logic [2:0]        nb;
  logic [WordW-1:0]  keep, end_word;
  logic [5:0]        sh;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digest_word = chain[out_idx];
  assign digest_last = (out_idx == 3'd4);

  // Masked end word with the pad byte after the valid bytes.
  always_comb begin
    nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    sh = 6'd32 - {nb, 3'b000};
    keep = (nb == 3'd0) ? '0 : ({WordW{1'b1}} << sh);
    end_word = (msg_word & keep) | ({24'd0, PadByte} << (sh - 6'd8));
  end

  // Schedule word for this round: stored word, or the expansion.
  always_comb begin
    w_x = rd0 ^ rd1 ^ rd2 ^ rd3;
    if (round < 7'd16) begin
      w_cur = rd0;
    end else begin
      w_cur = {w_x[30:0], w_x[31]};
    end
  end

  // Read addresses for the next round: w[t-16], w[t-14], w[t-8], w[t-3].
  logic [RoundW-1:0] rn;
  always_comb begin
    rn = (state == S_READ) ? '0 : round + 7'd1;
    ra0 = rn[SlotW-1:0];
    ra1 = rn[SlotW-1:0] + 4'd2;
    ra2 = rn[SlotW-1:0] + 4'd8;
    ra3 = rn[SlotW-1:0] + 4'd13;
  end

  // Write port: input, padding, or the expanded schedule word.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot;
    mem_wd = msg_word;
    unique case (state)
      S_IDLE: begin
        mem_we = acc;
        mem_wd = (acc && msg_end && nb != 3'd4) ? end_word : msg_word;
      end
      S_PAD: begin
        mem_we = 1'b1;
        mem_wd = pend_pad ? {PadByte, 24'd0} : '0;
      end
      S_LEN_HI: begin
        mem_we = 1'b1;
        mem_wd = bit_length[63:32];
      end
      S_LEN_LO: begin
        mem_we = 1'b1;
        mem_wd = bit_length[31:0];
      end
      S_ROUND: begin
        mem_we = 1'b1;
        mem_wa = round[SlotW-1:0];
        mem_wd = w_cur;
      end
      default: ;
    endcase
  end

  // Forwarding: a read of the entry written in the same cycle sees new data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd0 <= (mem_we && mem_wa == ra0) ? mem_wd : mem[ra0];
    rd1 <= (mem_we && mem_wa == ra1) ? mem_wd : mem[ra1];
    rd2 <= (mem_we && mem_wa == ra2) ? mem_wd : mem[ra2];
    rd3 <= (mem_we && mem_wa == ra3) ? mem_wd : mem[ra3];
  end

  assign rctl.start = (state == S_READ);
  assign rctl.step  = (state == S_ROUND);

  sha1_rounds u_rounds (
    .clk      (clk),
    .ctl      (rctl),
    .round    (round),
    .w_word   (w_cur),
    .chain_in ({chain[0], chain[1], chain[2], chain[3], chain[4]}),
    .work_out (work)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      bit_length <= '0;
      chain[0] <= Iv0; chain[1] <= Iv1; chain[2] <= Iv2;
      chain[3] <= Iv3; chain[4] <= Iv4;
      round <= '0;
      finishing <= 1'b0;
      pend_pad <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            slot <= slot + 4'd1;
            if (!msg_end) begin
              bit_length <= bit_length + 64'd32;
              if (slot == 4'd15) state <= S_READ;
            end else begin
              bit_length <= bit_length + {58'd0, nb, 3'b000};
              finishing <= 1'b1;
              pend_pad <= (nb == 3'd4);
              // A partial end word in slot 13 leaves room for the length only.
              if (slot == 4'd15) state <= S_READ;
              else if (slot == 4'd13 && nb != 3'd4) state <= S_LEN_HI;
              else state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // First pad word after a full end word carries the 0x80 byte.
          slot <= slot + 4'd1;
          pend_pad <= 1'b0;
          if (slot == 4'd15) state <= S_READ;
          else if (slot == 4'd13) state <= S_LEN_HI;
        end
        S_LEN_HI: begin
          slot <= slot + 4'd1;
          state <= S_LEN_LO;
        end
        S_LEN_LO: begin
          slot <= slot + 4'd1;
          finishing <= 1'b0;
          state <= S_READ;
        end
        S_READ: begin
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == 7'(Rounds - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          chain[0] <= chain[0] + work[5*WordW-1:4*WordW];
          chain[1] <= chain[1] + work[4*WordW-1:3*WordW];
          chain[2] <= chain[2] + work[3*WordW-1:2*WordW];
          chain[3] <= chain[3] + work[2*WordW-1:WordW];
          chain[4] <= chain[4] + work[WordW-1:0];
          if (finishing) state <= S_PAD;
          else if (done_msg) state <= S_OUT;
          else state <= S_IDLE;
          out_idx <= '0;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd4) begin
              state <= S_IDLE;
              chain[0] <= Iv0; chain[1] <= Iv1; chain[2] <= Iv2;
              chain[3] <= Iv3; chain[4] <= Iv4;
              bit_length <= '0;
              slot <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The length has been written: the block in hand is the last of the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_msg <= 1'b0;
    end else if (state == S_LEN_LO) begin
      done_msg <= 1'b1;
    end else if (state == S_OUT) begin
      done_msg <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // Input is never taken while a digest is pending.
  a_no_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input accepted during output");
  // The digest index stays in range.
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_idx <= 3'd4)) else $error("digest index out of range");
  // A compression runs exactly after a read setup.
  a_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_ROUND && round == '0))
    else $error("round start mismatch");
`endif

endmodule

`default_nettype wire
